[design/ssde_pkg.sv]
`default_nettype none

package ssde_pkg;

  localparam int unsigned ValueWidth = 16;
  localparam int unsigned SymWidth   = 4;
  localparam int unsigned CodeWidth  = 8;
  localparam int unsigned PcWidth    = 3;
  localparam int unsigned BitIdxWidth = 3;
  localparam int unsigned ConvWidth  = 5;
  localparam int unsigned BcdWidth   = 12;

  localparam logic [ValueWidth-1:0] MinFullValue = ValueWidth'(5);
  localparam logic [ConvWidth-1:0]  ConvSteps    = ConvWidth'(ValueWidth);

  typedef enum logic [2:0] {
    SRC_ZERO  = 3'd0,
    SRC_REC   = 3'd1,
    SRC_HUND  = 3'd2,
    SRC_TENS  = 3'd3,
    SRC_UNITS = 3'd4
  } src_e;

  typedef struct packed {
    src_e                   src;
    logic [BitIdxWidth-1:0] top;
    logic                   conv;
    logic                   fin;
  } ctrl_word_t;

  function automatic logic [CodeWidth-1:0] ssde_seg(input logic [SymWidth-1:0] sym);
    logic [CodeWidth-1:0] code;
    unique case (sym)
      4'd0:    code = 8'h5F;
      4'd1:    code = 8'h50;
      4'd2:    code = 8'h6D;
      4'd3:    code = 8'h79;
      4'd4:    code = 8'h72;
      4'd5:    code = 8'h3B;
      4'd6:    code = 8'h3F;
      4'd7:    code = 8'h51;
      4'd8:    code = 8'h7F;
      4'd9:    code = 8'h7B;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

  // One control word per field; two dot bits are fields of their own, the units field holds its dot.
  function automatic ctrl_word_t ssde_program(input logic [PcWidth-1:0] pc);
    ctrl_word_t cw;
    unique case (pc)
      3'd0:    cw = '{src: SRC_ZERO,  top: 3'd3, conv: 1'b1, fin: 1'b0};
      3'd1:    cw = '{src: SRC_REC,   top: 3'd6, conv: 1'b1, fin: 1'b0};
      3'd2:    cw = '{src: SRC_ZERO,  top: 3'd0, conv: 1'b1, fin: 1'b0};
      3'd3:    cw = '{src: SRC_ZERO,  top: 3'd6, conv: 1'b1, fin: 1'b0};
      3'd4:    cw = '{src: SRC_HUND,  top: 3'd6, conv: 1'b0, fin: 1'b0};
      3'd5:    cw = '{src: SRC_ZERO,  top: 3'd0, conv: 1'b0, fin: 1'b0};
      3'd6:    cw = '{src: SRC_TENS,  top: 3'd6, conv: 1'b0, fin: 1'b0};
      default: cw = '{src: SRC_UNITS, top: 3'd7, conv: 1'b0, fin: 1'b1};
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

[design/seven_segment_serial_display_encoder.sv]
`default_nettype none

// Channel   Direction  Ports                                       Transaction
// in        sink       in_valid_i, in_ready_o,                     one display request
//                      req_type_i, value_i, rec_symbol_i
// out       source     out_valid_o, out_ready_i,                   one serial bit
//                      seg_bit_o, last_o
//
// Each request yields 42 output transactions, one per cycle when out_ready_i is high.
// While a request is served, the program counter steps through eight field words.
// The decimal conversion shifts one value bit per emitted bit over the first 16 bits,
// so it is complete before the hundreds field.
// A new request is taken while the final bit still waits in the output register.
// Stalls on the output freeze the sequencer and the conversion together.
// Reset clears the sequencer and the output valid flag.
module seven_segment_serial_display_encoder
  import ssde_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  req_type_i,
  input  wire logic [ValueWidth-1:0] value_i,
  input  wire logic [SymWidth-1:0]   rec_symbol_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       seg_bit_o,
  output logic                       last_o
);

  logic                   busy_q;
  logic [PcWidth-1:0]     pc_q;
  logic [BitIdxWidth-1:0] bit_q;
  logic [ConvWidth-1:0]   conv_q;
  logic                   out_valid_q;
  logic [ValueWidth-1:0]  sh_q;
  logic [BcdWidth-1:0]    bcd_q;
  logic [BcdWidth-1:0]    bcd_adj;
  logic                   mode_q;
  logic [SymWidth-1:0]    rec_q;
  logic                   seg_bit_q;
  logic                   last_q;

  logic                   accept;
  logic                   adv;
  logic                   field_end;
  logic                   conv_step;
  ctrl_word_t             cw;
  logic [CodeWidth-1:0]   code;
  logic [ValueWidth-1:0]  eff_value;

  assign in_ready_o  = !busy_q;
  assign accept      = in_valid_i && !busy_q;
  assign adv         = busy_q && (!out_valid_q || out_ready_i);
  assign cw          = ssde_program(pc_q);
  assign field_end   = (bit_q == cw.top);
  assign conv_step   = adv && cw.conv && (conv_q != '0);
  assign out_valid_o = out_valid_q;
  assign seg_bit_o   = seg_bit_q;
  assign last_o      = last_q;

  always_comb begin
    if (!req_type_i && (value_i < MinFullValue)) begin
      eff_value = MinFullValue;
    end else begin
      eff_value = value_i;
    end
  end

  always_comb begin
    for (int i = 0; i < BcdWidth / 4; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    case (cw.src)
      SRC_REC:   code = mode_q ? '0 : ssde_seg(rec_q);
      SRC_HUND:  code = (mode_q || (bcd_q[11:8] == 4'd0)) ? '0 : ssde_seg(bcd_q[11:8]);
      SRC_TENS:  code = mode_q ? '0 : ssde_seg(bcd_q[7:4]);
      SRC_UNITS: code = ssde_seg(bcd_q[3:0]);
      default:   code = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= '0;
      bit_q       <= '0;
      conv_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
        pc_q   <= '0;
        bit_q  <= '0;
        conv_q <= ConvSteps;
      end else if (adv) begin
        if (field_end) begin
          bit_q <= '0;
          if (cw.fin) begin
            busy_q <= 1'b0;
            pc_q   <= '0;
          end else begin
            pc_q <= pc_q + PcWidth'(1);
          end
        end else begin
          bit_q <= bit_q + BitIdxWidth'(1);
        end
        if (conv_step) begin
          conv_q <= conv_q - ConvWidth'(1);
        end
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sh_q   <= eff_value;
      bcd_q  <= '0;
      mode_q <= req_type_i;
      rec_q  <= rec_symbol_i;
    end else if (conv_step) begin
      sh_q  <= {sh_q[ValueWidth-2:0], 1'b0};
      bcd_q <= {bcd_adj[BcdWidth-2:0], sh_q[ValueWidth-1]};
    end
    if (adv) begin
      seg_bit_q <= code[bit_q];
      last_q    <= cw.fin && field_end;
    end
  end

endmodule

`default_nettype wire

[dv/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ssde_pkg::*;

  localparam logic           ReqFull    = 1'b0;
  localparam logic           ReqUnits   = 1'b1;
  localparam logic [3:0]     SymBlank   = 4'd10;
  localparam int unsigned    CycleLimit = 400000;

  typedef struct packed {
    logic                  req_type;
    logic [ValueWidth-1:0] value;
    logic [SymWidth-1:0]   rec_symbol;
  } request_t;

  typedef struct packed {
    logic seg_bit;
    logic last;
  } serial_bit_t;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_ready_o;
  logic                  req_type_i   = 1'b0;
  logic [ValueWidth-1:0] value_i      = '0;
  logic [SymWidth-1:0]   rec_symbol_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i  = 1'b0;
  logic                  seg_bit_o;
  logic                  last_o;

  request_t    request_q[$];
  serial_bit_t frame_q[$];

  int unsigned n_sent     = 0;
  int unsigned n_driven   = 0;
  int unsigned n_taken    = 0;
  int unsigned bits_seen  = 0;
  int unsigned errors     = 0;
  int unsigned cycles     = 0;
  int unsigned sender_idle = 0;
  int unsigned sink_stall  = 0;

  seven_segment_serial_display_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .value_i     (value_i),
    .rec_symbol_i(rec_symbol_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .seg_bit_o   (seg_bit_o),
    .last_o      (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] segment_code(input logic [3:0] sym);
    logic [7:0] code;
    case (sym)
      4'd0:    code = 8'h5F;
      4'd1:    code = 8'h50;
      4'd2:    code = 8'h6D;
      4'd3:    code = 8'h79;
      4'd4:    code = 8'h72;
      4'd5:    code = 8'h3B;
      4'd6:    code = 8'h3F;
      4'd7:    code = 8'h51;
      4'd8:    code = 8'h7F;
      4'd9:    code = 8'h7B;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

  function automatic void append_code(input logic [7:0] code, input int n);
    for (int b = 0; b < n; b++) begin
      frame_q.push_back('{seg_bit: code[b], last: 1'b0});
    end
  endfunction

  // Frame order is position five down to position zero, each sent LSB first.
  function automatic void predict_frame(input request_t req);
    logic [ValueWidth-1:0] shown;
    int unsigned           hund;
    int unsigned           tens;
    int unsigned           units;
    logic [7:0]            blank;
    logic [7:0]            c4;
    logic [7:0]            c2;
    logic [7:0]            c1;
    logic [7:0]            c0;
    shown = req.value;
    if (req.req_type == ReqFull && shown < MinFullValue) begin
      shown = MinFullValue;
    end
    hund  = (shown / 100) % 10;
    tens  = (shown / 10) % 10;
    units = shown % 10;
    blank = segment_code(SymBlank);
    c4 = blank;
    c2 = blank;
    c1 = blank;
    c0 = segment_code(4'(units));
    if (req.req_type == ReqFull) begin
      c4 = segment_code(req.rec_symbol);
      c2 = (hund == 0) ? blank : segment_code(4'(hund));
      c1 = segment_code(4'(tens));
    end
    append_code(blank, 4);
    append_code(c4, 7);
    append_code(8'h00, 1);
    append_code(blank, 7);
    append_code(c2, 7);
    append_code(8'h00, 1);
    append_code(c1, 7);
    append_code(c0, 8);
    frame_q[frame_q.size() - 1].last = 1'b1;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic queue_request(input logic rt, input logic [ValueWidth-1:0] v,
                               input logic [SymWidth-1:0] rs);
    request_q.push_back('{req_type: rt, value: v, rec_symbol: rs});
    n_sent++;
  endtask

  task automatic wait_drained();
    while (n_taken != n_sent || frame_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    request_t next;
    if (rst_ni) begin
      if (n_taken == n_driven) begin
        if (request_q.size() != 0 && $urandom_range(99) >= sender_idle) begin
          next = request_q.pop_front();
          in_valid_i   <= 1'b1;
          req_type_i   <= next.req_type;
          value_i      <= next.value;
          rec_symbol_i <= next.rec_symbol;
          n_driven++;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(99) >= sink_stall);
    end
  end

  always @(posedge clk_i) begin
    serial_bit_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (frame_q.size() == 0) begin
          flag_mismatch("serial bit arrived with no frame pending");
        end else begin
          want = frame_q.pop_front();
          if (seg_bit_o !== want.seg_bit) begin
            flag_mismatch($sformatf("bit %0d: seg_bit %b, expected %b",
                                    bits_seen, seg_bit_o, want.seg_bit));
          end
          if (last_o !== want.last) begin
            flag_mismatch($sformatf("bit %0d: last %b, expected %b",
                                    bits_seen, last_o, want.last));
          end
        end
        bits_seen++;
      end
      if (in_valid_i && in_ready_o) begin
        predict_frame('{req_type: req_type_i, value: value_i, rec_symbol: rec_symbol_i});
        n_taken++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [ValueWidth-1:0] v;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle = 0;  sink_stall = 0;  end
        1: begin sender_idle = 81; sink_stall = 0;  end
        2: begin sender_idle = 0;  sink_stall = 81; end
        default: begin sender_idle = 14; sink_stall = 14; end
      endcase
      if (ph == 0) begin
        // Full-request values under five are raised, a zero hundreds digit is blanked, and
        // symbols from ten upwards are blank.
        queue_request(ReqFull,  16'd0,     4'd0);
        queue_request(ReqFull,  16'd2,     4'd14);
        queue_request(ReqFull,  16'd4,     4'd1);
        queue_request(ReqFull,  16'd5,     4'd2);
        queue_request(ReqFull,  16'd6,     4'd3);
        queue_request(ReqFull,  16'd9,     4'd4);
        queue_request(ReqFull,  16'd10,    4'd5);
        queue_request(ReqFull,  16'd99,    4'd6);
        queue_request(ReqFull,  16'd100,   4'd7);
        queue_request(ReqFull,  16'd105,   4'd8);
        queue_request(ReqFull,  16'd999,   4'd9);
        queue_request(ReqFull,  16'd1000,  4'd10);
        queue_request(ReqFull,  16'd1234,  4'd11);
        queue_request(ReqFull,  16'd32768, 4'd12);
        queue_request(ReqFull,  16'd12045, 4'd13);
        queue_request(ReqFull,  16'd65535, 4'd15);
        queue_request(ReqUnits, 16'd0,     4'd15);
        queue_request(ReqUnits, 16'd1,     4'd0);
        queue_request(ReqUnits, 16'd4,     4'd9);
        queue_request(ReqUnits, 16'd9,     4'd3);
        queue_request(ReqUnits, 16'd10,    4'd12);
        queue_request(ReqUnits, 16'd12347, 4'd7);
        queue_request(ReqUnits, 16'd32768, 4'd1);
        queue_request(ReqUnits, 16'd65535, 4'd15);
      end
      for (int half = 0; half < 2; half++) begin
        repeat (53) begin
          case ($urandom_range(3))
            0: v = ValueWidth'($urandom_range(9));
            1: v = ValueWidth'($urandom_range(1099));
            default: v = ValueWidth'($urandom_range(65535));
          endcase
          queue_request(1'($urandom_range(1)), v, SymWidth'($urandom_range(15)));
        end
        wait_drained();
      end
    end

    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
design/ssde_pkg.sv
design/seven_segment_serial_display_encoder.sv
dv/tb.sv
